// ===== design/pas_pkg.sv =====
// Shared types and constants for the positional array store.
package pas_pkg;

    localparam int DEPTH     = 128;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 7;
    localparam int COUNT_W   = 8;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
    localparam int CELL_CMP_W = (CMP_W > IDX_W) ? CMP_W : IDX_W;
    localparam int GRP       = 8;
    localparam int GRP_W     = 3;
    localparam int NGRP      = (DEPTH + GRP - 1) / GRP;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 24;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_MODIFY = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   count;
    } pas_ctl_t;

endpackage

// ===== design/pas_cell.sv =====
// One storage cell of the shifting chain, with its own equality compare.
module pas_cell (
    input  logic                           clk,
    input  pas_pkg::pas_ctl_t              ctl,
    input  logic [pas_pkg::IDX_W-1:0]      idx,
    input  logic [pas_pkg::DATA_W-1:0]     prev_data,
    input  logic [pas_pkg::DATA_W-1:0]     next_data,
    output logic [pas_pkg::DATA_W-1:0]     data,
    output logic                           match
);

    logic [pas_pkg::DATA_W-1:0]     data_reg;
    logic [pas_pkg::DATA_W-1:0]     data_next;
    logic                           match_reg;
    logic [pas_pkg::CELL_CMP_W-1:0] idx_ext;
    logic [pas_pkg::CELL_CMP_W-1:0] slot_ext;
    logic [pas_pkg::CELL_CMP_W-1:0] cnt_ext;

    assign idx_ext  = pas_pkg::CELL_CMP_W'(idx);
    assign slot_ext = pas_pkg::CELL_CMP_W'(ctl.slot);
    assign cnt_ext  = pas_pkg::CELL_CMP_W'(ctl.count);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.cmd)
            pas_pkg::CMD_INSERT:
            begin
                if (idx_ext > slot_ext)
                begin
                    data_next = prev_data;
                end
                else if (idx_ext == slot_ext)
                begin
                    data_next = ctl.value;
                end
            end
            pas_pkg::CMD_DELETE:
            begin
                if (idx_ext >= slot_ext)
                begin
                    data_next = next_data;
                end
            end
            pas_pkg::CMD_MODIFY:
            begin
                if (idx_ext == slot_ext)
                begin
                    data_next = ctl.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.cmd == pas_pkg::CMD_SEARCH)
        begin
            match_reg <= (data_reg == ctl.value) && (idx_ext < cnt_ext);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== design/pas_find.sv =====
// Two-level lowest-index encoder over the cells' match flags.
module pas_find (
    input  logic                        clk,
    input  logic [pas_pkg::DEPTH-1:0]   match,
    output logic                        hit,
    output logic [pas_pkg::IDX_W-1:0]   index
);

    logic [pas_pkg::NGRP*pas_pkg::GRP-1:0] match_pad;
    logic [pas_pkg::NGRP-1:0]              grp_hit_reg;
    logic [pas_pkg::GRP_W-1:0]             grp_idx_reg [pas_pkg::NGRP];
    logic [pas_pkg::NGRP-1:0]              grp_hit_next;
    logic [pas_pkg::GRP_W-1:0]             grp_idx_next [pas_pkg::NGRP];
    logic [pas_pkg::IDX_W+pas_pkg::GRP_W-1:0] wide_idx;

    assign match_pad = (pas_pkg::NGRP*pas_pkg::GRP)'(match);

    always_comb
    begin
        for (int g = 0; g < pas_pkg::NGRP; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = pas_pkg::GRP - 1; b >= 0; b--)
            begin
                if (match_pad[g*pas_pkg::GRP + b])
                begin
                    grp_hit_next[g] = 1'b1;
                    grp_idx_next[g] = pas_pkg::GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_hit_reg <= grp_hit_next;
        for (int g = 0; g < pas_pkg::NGRP; g++)
        begin
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        wide_idx = '0;
        for (int g = pas_pkg::NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                hit      = 1'b1;
                wide_idx = (pas_pkg::IDX_W+pas_pkg::GRP_W)'(g * pas_pkg::GRP)
                         + (pas_pkg::IDX_W+pas_pkg::GRP_W)'(grp_idx_reg[g]);
            end
        end
    end

    assign index = wide_idx[pas_pkg::IDX_W-1:0];

endmodule

// ===== design/positional_array_store.sv =====
// Top level of the positional array store: control, cell chain and result register.
// An ordered list of up to 128 signed 32-bit values held in a chain of cells that
// shift together. Every operation passes an execute state before its result, and search
// adds a find state: a registered compare in every cell, then a two-level encoder for
// the lowest match, registered after its first level. One operation is in flight at a
// time; a new beat is taken once the previous result sits in the output register.
module positional_array_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pas_pkg::IN_W-1:0]   s_tdata,  // func[1:0], value[33:2], slot[41:34]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pas_pkg::OUT_W-1:0]  m_tdata   // status[2:0], found_index[9:3], count[17:10]
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_FIND = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    logic [pas_pkg::FUNC_W-1:0]       func_reg;
    logic [pas_pkg::DATA_W-1:0]       value_reg;
    logic [pas_pkg::SLOT_W-1:0]       slot_reg;
    logic [pas_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [pas_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic                             out_valid_reg;
    logic [pas_pkg::STATUS_W-1:0]     out_status_reg;
    logic [pas_pkg::INDEX_W-1:0]      out_index_reg;
    logic [pas_pkg::COUNT_W-1:0]      out_count_reg;

    pas_pkg::pas_ctl_t                ctl;
    logic [pas_pkg::CMP_W-1:0]        slot_ext, cnt_ext;
    logic [pas_pkg::DATA_W-1:0]       cell_data [pas_pkg::DEPTH];
    logic [pas_pkg::DEPTH-1:0]        cell_match;
    logic                             find_hit;
    logic [pas_pkg::IDX_W-1:0]        find_index;
    logic                             out_free;
    logic                             in_beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign slot_ext = pas_pkg::CMP_W'(slot_reg);
    assign cnt_ext  = pas_pkg::CMP_W'(cnt_reg);

    always_comb
    begin
        status_next = pas_pkg::STAT_OK;
        cnt_next    = cnt_reg;
        ctl.cmd     = pas_pkg::CMD_HOLD;
        ctl.slot    = slot_reg;
        ctl.value   = value_reg;
        ctl.count   = cnt_reg;
        if (state_reg == ST_EXEC)
        begin
            unique case (func_reg)
                pas_pkg::FUNC_INSERT:
                begin
                    if (cnt_ext == pas_pkg::CMP_W'(pas_pkg::DEPTH))
                    begin
                        status_next = pas_pkg::STAT_FULL;
                    end
                    else if (slot_ext > cnt_ext)
                    begin
                        status_next = pas_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        ctl.cmd  = pas_pkg::CMD_INSERT;
                        cnt_next = cnt_reg + pas_pkg::CNT_W'(1);
                    end
                end
                pas_pkg::FUNC_DELETE:
                begin
                    if (cnt_reg == '0)
                    begin
                        status_next = pas_pkg::STAT_EMPTY;
                    end
                    else if (slot_ext >= cnt_ext)
                    begin
                        status_next = pas_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        ctl.cmd  = pas_pkg::CMD_DELETE;
                        cnt_next = cnt_reg - pas_pkg::CNT_W'(1);
                    end
                end
                pas_pkg::FUNC_MODIFY:
                begin
                    if (slot_ext >= cnt_ext)
                    begin
                        status_next = pas_pkg::STAT_BADPOS;
                    end
                    else
                    begin
                        ctl.cmd = pas_pkg::CMD_MODIFY;
                    end
                end
                pas_pkg::FUNC_SEARCH:
                begin
                    ctl.cmd = pas_pkg::CMD_SEARCH;
                end
                default:
                begin
                    ctl.cmd = pas_pkg::CMD_HOLD;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (func_reg == pas_pkg::FUNC_SEARCH) ? ST_FIND : ST_DONE;
            end
            ST_FIND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            func_reg  <= s_tdata[1:0];
            value_reg <= s_tdata[33:2];
            slot_reg  <= s_tdata[41:34];
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg <= status_next;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_count_reg <= pas_pkg::COUNT_W'({{pas_pkg::COUNT_W{1'b0}}, cnt_reg});
            if (func_reg == pas_pkg::FUNC_SEARCH)
            begin
                out_status_reg <= find_hit ? pas_pkg::STAT_OK : pas_pkg::STAT_NOTFOUND;
                out_index_reg  <= find_hit
                    ? pas_pkg::INDEX_W'({{pas_pkg::INDEX_W{1'b0}}, find_index})
                    : '0;
            end
            else
            begin
                out_status_reg <= status_reg;
                out_index_reg  <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < pas_pkg::DEPTH; i++)
        begin : g_cell
            pas_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .idx       (pas_pkg::IDX_W'(i)),
                .prev_data ((i == 0) ? value_reg : cell_data[(i == 0) ? 0 : i - 1]),
                .next_data (cell_data[(i == pas_pkg::DEPTH - 1) ? i : i + 1]),
                .data      (cell_data[i]),
                .match     (cell_match[i])
            );
        end
    endgenerate

    pas_find u_find (
        .clk   (clk),
        .match (cell_match),
        .hit   (find_hit),
        .index (find_index)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_index_reg, out_status_reg};

endmodule
